/* src/bpa_pkg.sv */
// Shared types and constants for the buddy page allocator.
`default_nettype none
package bpa_pkg;

  // Order field width and the tag value for a page that heads no free block.
  localparam int unsigned OrderW = 4;
  localparam logic [OrderW-1:0] TagNone = 4'hF;

  // Default pool geometry.
  localparam int unsigned DefNumPages = 4096;
  localparam int unsigned DefMaxOrder = 10;

  // Request operation codes.
  localparam logic OpAlloc = 1'b0;
  localparam logic OpFree = 1'b1;

  // Per-array write enables of the page memory.
  typedef struct packed {
    logic tag;
    logic nxt;
    logic prv;
  } bpa_we_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH,
    S_FCK0,
    S_FLOOP,
    S_FCHK,
    S_RM1,
    S_RM2,
    S_RM3,
    S_SPLIT,
    S_PU1,
    S_PU2,
    S_FIN,
    S_DONE
  } bpa_state_e;

endpackage
`default_nettype wire

/* src/bpa_mem.sv */
// Per-page tag and link memory with its post-reset initialization sweep.
`default_nettype none
module bpa_mem #(
  parameter int unsigned NUM_PAGES = bpa_pkg::DefNumPages,
  parameter int unsigned MAX_ORDER = bpa_pkg::DefMaxOrder,
  localparam int unsigned PW = $clog2(NUM_PAGES),
  localparam int unsigned LW = PW + 1
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [PW-1:0]                 addr_i,
  input  wire logic                          rd_i,
  input  wire bpa_pkg::bpa_we_t              we_i,
  input  wire logic [bpa_pkg::OrderW-1:0]    tag_wd_i,
  input  wire logic [LW-1:0]                 nxt_wd_i,
  input  wire logic [LW-1:0]                 prv_wd_i,
  output logic      [bpa_pkg::OrderW-1:0]    tag_rd_o,
  output logic      [LW-1:0]                 nxt_rd_o,
  output logic      [LW-1:0]                 prv_rd_o,
  output logic                               busy_o
);

  localparam int unsigned TopBlocks = NUM_PAGES >> MAX_ORDER;
  localparam int unsigned PoolPages = TopBlocks << MAX_ORDER;
  localparam logic [LW-1:0] LinkNone = LW'(NUM_PAGES);
  localparam logic [LW-1:0] LowMask = LW'((1 << MAX_ORDER) - 1);

  logic [bpa_pkg::OrderW-1:0] tag_mem [NUM_PAGES];
  logic [LW-1:0]              nxt_mem [NUM_PAGES];
  logic [LW-1:0]              prv_mem [NUM_PAGES];

  logic [LW-1:0] clr_q, clr_d;
  logic          busy_q, busy_d;

  logic [LW-1:0]              blk;
  logic                       is_head;
  logic [PW-1:0]              waddr;
  bpa_pkg::bpa_we_t           we;
  logic [bpa_pkg::OrderW-1:0] tag_wd;
  logic [LW-1:0]              nxt_wd, prv_wd;

  // Sweep counter: one page per cycle after reset.
  always_comb begin
    clr_d  = clr_q;
    busy_d = busy_q;
    if (busy_q) begin
      clr_d = clr_q + LW'(1);
      if (clr_q == LW'(NUM_PAGES - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q  <= '0;
      busy_q <= 1'b1;
    end else begin
      clr_q  <= clr_d;
      busy_q <= busy_d;
    end
  end

  // Initial contents: top blocks chained with the highest block first.
  always_comb begin
    blk     = clr_q >> MAX_ORDER;
    is_head = ((clr_q & LowMask) == '0) && (clr_q < LW'(PoolPages));
    if (busy_q) begin
      waddr  = clr_q[PW-1:0];
      we     = '{tag: 1'b1, nxt: 1'b1, prv: 1'b1};
      tag_wd = is_head ? bpa_pkg::OrderW'(MAX_ORDER) : bpa_pkg::TagNone;
      nxt_wd = (is_head && blk != '0) ? ((blk - LW'(1)) << MAX_ORDER) : LinkNone;
      prv_wd = (is_head && (blk + LW'(1)) < LW'(TopBlocks)) ?
               ((blk + LW'(1)) << MAX_ORDER) : LinkNone;
    end else begin
      waddr  = addr_i;
      we     = we_i;
      tag_wd = tag_wd_i;
      nxt_wd = nxt_wd_i;
      prv_wd = prv_wd_i;
    end
  end

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we.tag) begin
      tag_mem[waddr] <= tag_wd;
    end
    if (we.nxt) begin
      nxt_mem[waddr] <= nxt_wd;
    end
    if (we.prv) begin
      prv_mem[waddr] <= prv_wd;
    end
  end

  // Registered read port; data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (rd_i) begin
      tag_rd_o <= tag_mem[addr_i];
      nxt_rd_o <= nxt_mem[addr_i];
      prv_rd_o <= prv_mem[addr_i];
    end
  end

  assign busy_o = busy_q;

endmodule
`default_nettype wire

/* src/buddy_page_allocator.sv */
// Buddy page allocator: request sequencer, free lists and result register.
// Alloc searches the free lists upward from the requested order, unlinks the block found
// and splits it down level by level; free checks the page, merges it with each free buddy
// below the top order and pushes the result; a rejected request goes straight to the result.
// One request at a time: every step goes through the single page memory port.
// After reset the page memory is swept over all NUM_PAGES pages before the first request.
`default_nettype none
module buddy_page_allocator #(
  parameter int unsigned NUM_PAGES = bpa_pkg::DefNumPages,
  parameter int unsigned MAX_ORDER = bpa_pkg::DefMaxOrder,
  localparam int unsigned PW = $clog2(NUM_PAGES),
  localparam int unsigned LW = PW + 1
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic                       op_i,
  input  wire logic [bpa_pkg::OrderW-1:0] order_i,
  input  wire logic [PW-1:0]              page_index_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic                            status_o,
  output logic      [PW-1:0]              page_index_res_o,
  output logic      [LW-1:0]              free_count_o
);

  localparam int unsigned TopBlocks = NUM_PAGES >> MAX_ORDER;
  localparam int unsigned PoolPages = TopBlocks << MAX_ORDER;
  localparam int unsigned KW = $clog2(MAX_ORDER + 1);
  localparam logic [LW-1:0] LinkNone = LW'(NUM_PAGES);
  localparam logic [bpa_pkg::OrderW-1:0] MaxOrd = bpa_pkg::OrderW'(MAX_ORDER);

  bpa_pkg::bpa_state_e state_q, state_d;
  logic                       op_q, op_d;
  logic [bpa_pkg::OrderW-1:0] ord_q, ord_d, k_q, k_d;
  logic [PW-1:0]              p_q, p_d, a_q, a_d, res_q, res_d;
  logic [LW-1:0]              n_q, n_d, v_q, v_d, h_q, h_d;
  logic                       status_q, status_d;
  logic [LW-1:0]              head_q [MAX_ORDER+1];
  logic [LW-1:0]              cnt_q  [MAX_ORDER+1];

  logic                       head_we, cnt_inc, cnt_dec;
  logic [LW-1:0]              head_wd, hd, bud;
  logic [KW-1:0]              kx;
  logic [31:0]                amask;

  logic [PW-1:0]              mem_addr;
  logic                       mem_rd, mem_busy;
  bpa_pkg::bpa_we_t           mem_we;
  logic [bpa_pkg::OrderW-1:0] tag_wd, tag_rd;
  logic [LW-1:0]              nxt_wd, prv_wd, nxt_rd, prv_rd;

  bpa_mem #(
    .NUM_PAGES(NUM_PAGES),
    .MAX_ORDER(MAX_ORDER)
  ) u_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .addr_i   (mem_addr),
    .rd_i     (mem_rd),
    .we_i     (mem_we),
    .tag_wd_i (tag_wd),
    .nxt_wd_i (nxt_wd),
    .prv_wd_i (prv_wd),
    .tag_rd_o (tag_rd),
    .nxt_rd_o (nxt_rd),
    .prv_rd_o (prv_rd),
    .busy_o   (mem_busy)
  );

  assign kx    = k_q[KW-1:0];
  assign hd    = head_q[kx];
  assign bud   = {1'b0, p_q} ^ (LW'(1) << k_q);
  assign amask = (32'd1 << order_i) - 32'd1;

  // Sequencer: next state, memory commands and free-list updates.
  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    ord_d    = ord_q;
    k_d      = k_q;
    p_d      = p_q;
    a_d      = a_q;
    n_d      = n_q;
    v_d      = v_q;
    h_d      = h_q;
    status_d = status_q;
    res_d    = res_q;
    mem_addr = a_q;
    mem_rd   = 1'b0;
    mem_we   = '0;
    tag_wd   = bpa_pkg::TagNone;
    nxt_wd   = LinkNone;
    prv_wd   = LinkNone;
    head_we  = 1'b0;
    head_wd  = n_q;
    cnt_inc  = 1'b0;
    cnt_dec  = 1'b0;
    case (state_q)
      bpa_pkg::S_IDLE: begin
        if (in_valid_i && !mem_busy) begin
          op_d     = op_i;
          ord_d    = order_i;
          k_d      = order_i;
          p_d      = page_index_i;
          status_d = 1'b1;
          res_d    = '0;
          if (order_i > MaxOrd) begin
            state_d = bpa_pkg::S_FIN;
          end else if (op_i == bpa_pkg::OpAlloc) begin
            state_d = bpa_pkg::S_SRCH;
          end else if (32'(page_index_i) >= 32'(PoolPages) ||
                       (32'(page_index_i) & amask) != 32'd0) begin
            state_d = bpa_pkg::S_FIN;
          end else begin
            mem_addr = page_index_i;
            mem_rd   = 1'b1;
            state_d  = bpa_pkg::S_FCK0;
          end
        end
      end
      // Find the lowest non-empty list at or above the request.
      bpa_pkg::S_SRCH: begin
        if (k_q > MaxOrd) begin
          state_d = bpa_pkg::S_FIN;
        end else if (hd != LinkNone) begin
          a_d      = hd[PW-1:0];
          p_d      = hd[PW-1:0];
          mem_addr = hd[PW-1:0];
          mem_rd   = 1'b1;
          state_d  = bpa_pkg::S_RM1;
        end else begin
          k_d = k_q + 4'd1;
        end
      end
      // A page that already heads a free block cannot be freed again.
      bpa_pkg::S_FCK0: begin
        state_d = (tag_rd != bpa_pkg::TagNone) ? bpa_pkg::S_FIN : bpa_pkg::S_FLOOP;
      end
      bpa_pkg::S_FLOOP: begin
        if (k_q < MaxOrd && bud < LW'(PoolPages)) begin
          a_d      = bud[PW-1:0];
          mem_addr = bud[PW-1:0];
          mem_rd   = 1'b1;
          state_d  = bpa_pkg::S_FCHK;
        end else begin
          a_d     = p_q;
          state_d = bpa_pkg::S_PU1;
        end
      end
      bpa_pkg::S_FCHK: begin
        if (tag_rd == k_q) begin
          state_d = bpa_pkg::S_RM1;
        end else begin
          a_d     = p_q;
          state_d = bpa_pkg::S_PU1;
        end
      end
      // Unlink: predecessor (or list head) takes the successor.
      bpa_pkg::S_RM1: begin
        n_d = nxt_rd;
        v_d = prv_rd;
        if (prv_rd == LinkNone) begin
          head_we = 1'b1;
          head_wd = nxt_rd;
        end else begin
          mem_addr   = prv_rd[PW-1:0];
          mem_we.nxt = 1'b1;
          nxt_wd     = nxt_rd;
        end
        state_d = bpa_pkg::S_RM2;
      end
      bpa_pkg::S_RM2: begin
        if (n_q != LinkNone) begin
          mem_addr   = n_q[PW-1:0];
          mem_we.prv = 1'b1;
          prv_wd     = v_q;
        end
        state_d = bpa_pkg::S_RM3;
      end
      bpa_pkg::S_RM3: begin
        mem_we  = '{tag: 1'b1, nxt: 1'b1, prv: 1'b1};
        cnt_dec = 1'b1;
        if (op_q == bpa_pkg::OpAlloc) begin
          state_d = bpa_pkg::S_SPLIT;
        end else begin
          p_d     = p_q & a_q;
          k_d     = k_q + 4'd1;
          state_d = bpa_pkg::S_FLOOP;
        end
      end
      // Push the upper half of each split onto the next lower list.
      bpa_pkg::S_SPLIT: begin
        if (k_q > ord_q) begin
          k_d     = k_q - 4'd1;
          a_d     = p_q | (PW'(1) << (k_q - 4'd1));
          state_d = bpa_pkg::S_PU1;
        end else begin
          status_d = 1'b0;
          res_d    = p_q;
          state_d  = bpa_pkg::S_FIN;
        end
      end
      bpa_pkg::S_PU1: begin
        mem_we  = '{tag: 1'b1, nxt: 1'b1, prv: 1'b1};
        nxt_wd  = hd;
        tag_wd  = k_q;
        head_we = 1'b1;
        head_wd = {1'b0, a_q};
        cnt_inc = 1'b1;
        h_d     = hd;
        state_d = bpa_pkg::S_PU2;
      end
      bpa_pkg::S_PU2: begin
        if (h_q != LinkNone) begin
          mem_addr   = h_q[PW-1:0];
          mem_we.prv = 1'b1;
          prv_wd     = {1'b0, a_q};
        end
        if (op_q == bpa_pkg::OpAlloc) begin
          state_d = bpa_pkg::S_SPLIT;
        end else begin
          status_d = 1'b0;
          state_d  = bpa_pkg::S_FIN;
        end
      end
      bpa_pkg::S_FIN: begin
        k_d     = ord_q;
        state_d = bpa_pkg::S_DONE;
      end
      bpa_pkg::S_DONE: begin
        if (!out_stall_i) begin
          state_d = bpa_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = bpa_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers and per-order list heads and counts.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bpa_pkg::S_IDLE;
      for (int i = 0; i <= MAX_ORDER; i++) begin
        head_q[i] <= LinkNone;
        cnt_q[i]  <= '0;
      end
      head_q[MAX_ORDER] <= (TopBlocks > 0) ? LW'((TopBlocks - 1) << MAX_ORDER) : LinkNone;
      cnt_q[MAX_ORDER]  <= LW'(TopBlocks);
    end else begin
      state_q <= state_d;
      if (head_we) begin
        head_q[kx] <= head_wd;
      end
      if (cnt_inc) begin
        cnt_q[kx] <= cnt_q[kx] + LW'(1);
      end else if (cnt_dec) begin
        cnt_q[kx] <= cnt_q[kx] - LW'(1);
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    ord_q    <= ord_d;
    k_q      <= k_d;
    p_q      <= p_d;
    a_q      <= a_d;
    n_q      <= n_d;
    v_q      <= v_d;
    h_q      <= h_d;
    status_q <= status_d;
    res_q    <= res_d;
  end

  assign in_stall_o       = mem_busy || (state_q != bpa_pkg::S_IDLE);
  assign out_valid_o      = (state_q == bpa_pkg::S_DONE);
  assign status_o         = status_q;
  assign page_index_res_o = res_q;
  assign free_count_o     = (ord_q <= MaxOrd) ? cnt_q[kx] : '0;

  // A request is taken only when the sequencer is idle and the sweep is over.
  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q != bpa_pkg::S_IDLE))
    else $error("request taken but sequencer stayed idle");

  a_sweep_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_busy |-> in_stall_o)
    else $error("request port open during memory sweep");

  // A granted block is aligned to its order.
  a_alloc_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !status_o && op_q == bpa_pkg::OpAlloc) |->
      ((32'(page_index_res_o) & ((32'd1 << ord_q) - 32'd1)) == 32'd0))
    else $error("allocated block misaligned");

  // Free results never carry a page.
  a_free_page: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && op_q == bpa_pkg::OpFree) |-> (page_index_res_o == '0))
    else $error("free result carries a page");

endmodule
`default_nettype wire
